@@ rtl/pfmc_pkg.sv @@
`timescale 1ns / 1ps

package pfmc_pkg;

	localparam int TYPE_W  = 10;
	localparam int CUST_W  = 8;
	localparam int COUNT_W = 16;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	localparam int NUM_TYPES_DEF     = 1024;
	localparam int NUM_CUSTOMERS_DEF = 256;
	localparam int NODE_COUNT_DEF    = 1024;

	// commands from the controller, at most one high per cycle
	typedef struct packed {
		logic clr_step;     // clear one entry of the type and count stores
		logic accept;       // latch the word, read type entry and free list link
		logic ord_commit;   // finish an order and load the result
		logic srv_empty;    // finish a serve that found nobody waiting
		logic srv_node_rd;  // read owner and link of the head node
		logic srv_link;     // unlink head, return node, read served count
		logic srv_commit;   // write count and load the result
	} pfmc_cmd_t;

	typedef struct packed {
		logic clr_last;     // clearing pass at its last entry
		logic is_serve;     // latched word is a serve
		logic hit;          // type in range and its queue holds a customer
		logic out_free;     // result register can take a new word
	} pfmc_stat_t;

endpackage

@@ rtl/pfmc_ctrl.sv @@
`timescale 1ns / 1ps

module pfmc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  pfmc_pkg::pfmc_stat_t stat,
	output pfmc_pkg::pfmc_cmd_t  cmd
);
	import pfmc_pkg::*;

	typedef enum logic [2:0] {
		S_CLR,
		S_IDLE,
		S_DEC,
		S_LINK,
		S_CNT
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		case (state_q)
			S_CLR:  cmd.clr_step = 1'b1;
			S_IDLE: cmd.accept = in_valid;
			S_DEC: begin
				if (!stat.is_serve) begin
					cmd.ord_commit = stat.out_free;
				end else if (stat.hit) begin
					cmd.srv_node_rd = 1'b1;
				end else begin
					cmd.srv_empty = stat.out_free;
				end
			end
			S_LINK: cmd.srv_link = 1'b1;
			S_CNT:  cmd.srv_commit = stat.out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			case (state_q)
				S_CLR: begin
					if (stat.clr_last) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) state_q <= S_DEC;
				end
				S_DEC: begin
					if (cmd.srv_node_rd) state_q <= S_LINK;
					else if (cmd.ord_commit || cmd.srv_empty) state_q <= S_IDLE;
				end
				S_LINK: state_q <= S_CNT;
				S_CNT: begin
					if (cmd.srv_commit) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("more than one datapath command in a cycle");

	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.ord_commit || cmd.srv_empty || cmd.srv_commit) |-> stat.out_free)
		else $error("result loaded while the output register is still full");

	a_link_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.srv_link |-> $past(cmd.srv_node_rd))
		else $error("unlink without a head node read just before");
`endif

endmodule

@@ rtl/pfmc_dp.sv @@
`timescale 1ns / 1ps

module pfmc_dp #(
	parameter int NUM_TYPES     = pfmc_pkg::NUM_TYPES_DEF,
	parameter int NUM_CUSTOMERS = pfmc_pkg::NUM_CUSTOMERS_DEF,
	parameter int NODE_COUNT    = pfmc_pkg::NODE_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pfmc_pkg::pfmc_cmd_t           cmd,
	output pfmc_pkg::pfmc_stat_t          stat,
	input  logic                          func,
	input  logic [pfmc_pkg::TYPE_W-1:0]   item_type,
	input  logic [pfmc_pkg::CUST_W-1:0]   customer,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          matched,
	output logic [pfmc_pkg::CUST_W-1:0]   served_customer,
	output logic [pfmc_pkg::COUNT_W-1:0]  new_count,
	output logic                          dropped
);
	import pfmc_pkg::*;

	localparam int TIW   = $clog2(NUM_TYPES);
	localparam int CIW   = $clog2(NUM_CUSTOMERS);
	localparam int NW    = $clog2(NODE_COUNT);
	localparam int NCW   = NW + 1;
	localparam int TE_W  = 1 + 2 * NW;
	localparam int CLR_N = (NUM_TYPES > NUM_CUSTOMERS) ? NUM_TYPES : NUM_CUSTOMERS;
	localparam int CLRW  = $clog2(CLR_N);

	// type entry: {nonempty, head, tail}
	logic [TE_W-1:0]    type_mem  [NUM_TYPES];
	logic [NW-1:0]      next_mem  [NODE_COUNT];
	logic [CUST_W-1:0]  owner_mem [NODE_COUNT];
	logic [COUNT_W-1:0] count_mem [NUM_CUSTOMERS];

	logic [CLRW-1:0]    clr_q;
	logic               func_q;
	logic [TYPE_W-1:0]  item_type_q;
	logic [CUST_W-1:0]  cust_q;
	logic [TE_W-1:0]    type_rd_q;
	logic [NW-1:0]      next_rd_q;
	logic [CUST_W-1:0]  owner_rd_q;
	logic [COUNT_W-1:0] count_rd_q;
	logic [NCW-1:0]     fresh_q;
	logic [NW-1:0]      free_head_q;
	logic               free_valid_q;

	logic               out_valid_q;
	logic               matched_q;
	logic [CUST_W-1:0]  served_customer_q;
	logic [COUNT_W-1:0] new_count_q;
	logic               dropped_q;

	logic               rd_nonempty;
	logic [NW-1:0]      rd_head;
	logic [NW-1:0]      rd_tail;
	logic               type_ok;
	logic               cust_ok;
	logic               node_avail;
	logic               ord_ok;
	logic [NW-1:0]      new_node;
	logic [TIW-1:0]     type_idx;
	logic [COUNT_W-1:0] count_inc;

	logic               type_we;
	logic [TIW-1:0]     type_wa;
	logic [TE_W-1:0]    type_wd;
	logic               next_we;
	logic [NW-1:0]      next_wa;
	logic [NW-1:0]      next_wd;
	logic [NW-1:0]      next_ra;
	logic               count_we;
	logic [CIW-1:0]     count_wa;
	logic [COUNT_W-1:0] count_wd;
	logic               clr_type_en;
	logic               clr_cust_en;

	assign rd_nonempty = type_rd_q[TE_W-1];
	assign rd_head     = type_rd_q[2*NW-1:NW];
	assign rd_tail     = type_rd_q[NW-1:0];
	assign type_ok     = 32'(item_type_q) < NUM_TYPES;
	assign cust_ok     = 32'(cust_q) < NUM_CUSTOMERS;
	assign node_avail  = free_valid_q || (fresh_q < NCW'(NODE_COUNT));
	assign ord_ok      = type_ok && cust_ok && node_avail;
	assign new_node    = free_valid_q ? free_head_q : fresh_q[NW-1:0];
	assign type_idx    = TIW'(item_type_q);
	assign count_inc   = (count_rd_q == COUNT_MAX) ? COUNT_MAX : count_rd_q + COUNT_W'(1);
	assign clr_type_en = 32'(clr_q) < NUM_TYPES;
	assign clr_cust_en = 32'(clr_q) < NUM_CUSTOMERS;

	assign stat.clr_last = (clr_q == CLRW'(CLR_N - 1));
	assign stat.is_serve = func_q;
	assign stat.hit      = type_ok && rd_nonempty;
	assign stat.out_free = !out_valid_q || out_ready;

	assign out_valid       = out_valid_q;
	assign matched         = matched_q;
	assign served_customer = served_customer_q;
	assign new_count       = new_count_q;
	assign dropped         = dropped_q;

	// write port selection
	always_comb begin
		type_we  = 1'b0;
		type_wa  = type_idx;
		type_wd  = '0;
		next_we  = 1'b0;
		next_wa  = rd_tail;
		next_wd  = new_node;
		count_we = 1'b0;
		count_wa = CIW'(owner_rd_q);
		count_wd = count_inc;
		if (cmd.clr_step) begin
			type_we  = clr_type_en;
			type_wa  = TIW'(clr_q);
			count_we = clr_cust_en;
			count_wa = CIW'(clr_q);
			count_wd = '0;
		end else if (cmd.ord_commit && ord_ok) begin
			type_we = 1'b1;
			type_wd = rd_nonempty ? {1'b1, rd_head, new_node} : {1'b1, new_node, new_node};
			next_we = rd_nonempty;
		end else if (cmd.srv_link) begin
			// last node leaves the queue empty, else head moves to its link
			type_we = 1'b1;
			type_wd = {(rd_head != rd_tail), next_rd_q, rd_tail};
			next_we = 1'b1;
			next_wa = rd_head;
			next_wd = free_valid_q ? free_head_q : rd_head;
		end else if (cmd.srv_commit) begin
			count_we = 1'b1;
		end
	end

	assign next_ra = cmd.srv_node_rd ? rd_head : free_head_q;

	always_ff @(posedge clk) begin
		if (type_we) type_mem[type_wa] <= type_wd;
		if (cmd.accept) type_rd_q <= type_mem[TIW'(item_type)];
	end

	always_ff @(posedge clk) begin
		if (next_we) next_mem[next_wa] <= next_wd;
		if (cmd.accept || cmd.srv_node_rd) next_rd_q <= next_mem[next_ra];
	end

	always_ff @(posedge clk) begin
		if (cmd.ord_commit && ord_ok) owner_mem[new_node] <= cust_q;
		if (cmd.srv_node_rd) owner_rd_q <= owner_mem[rd_head];
	end

	always_ff @(posedge clk) begin
		if (count_we) count_mem[count_wa] <= count_wd;
		if (cmd.srv_link) count_rd_q <= count_mem[CIW'(owner_rd_q)];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			func_q      <= func;
			item_type_q <= item_type;
			cust_q      <= customer;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q        <= '0;
			fresh_q      <= '0;
			free_head_q  <= '0;
			free_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_step && !stat.clr_last) clr_q <= clr_q + CLRW'(1);
			if (cmd.ord_commit && ord_ok) begin
				if (free_valid_q) begin
					// a node linked to itself ends the free list
					if (next_rd_q == free_head_q) free_valid_q <= 1'b0;
					else free_head_q <= next_rd_q;
				end else begin
					fresh_q <= fresh_q + NCW'(1);
				end
			end
			if (cmd.srv_link) begin
				free_head_q  <= rd_head;
				free_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.ord_commit || cmd.srv_empty || cmd.srv_commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ord_commit || cmd.srv_empty) begin
			matched_q         <= 1'b0;
			served_customer_q <= '0;
			new_count_q       <= '0;
			dropped_q         <= cmd.ord_commit && !ord_ok;
		end else if (cmd.srv_commit) begin
			matched_q         <= 1'b1;
			served_customer_q <= owner_rd_q;
			new_count_q       <= count_inc;
			dropped_q         <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_fresh_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fresh_q <= NCW'(NODE_COUNT))
		else $error("fresh node count beyond the node store");

	a_free_after_link: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.srv_link |=> free_valid_q)
		else $error("returned node missing from the free list");

	a_out_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(matched_q && dropped_q))
		else $error("result both matched and dropped");
`endif

endmodule

@@ rtl/per_key_fifo_match_counter.sv @@
`timescale 1ns / 1ps

// per-type customer queues sharing one linked node store
// input channel (in_valid/in_ready): one word holds func, item_type, customer;
//   func 0 appends the customer to the queue of item_type, func 1 serves the
//   oldest customer waiting on that type
// output channel (out_valid/out_ready): exactly one word per input word, in order,
//   carrying matched, served_customer, new_count (saturating) and dropped
// an order reads the type entry and free list link on acceptance, then does
//   the node and pointer writes
// a serve reads the type entry, then, with a customer waiting, the head node,
//   then unlinks it while reading the served count, then writes the count
// one word is in flight at a time; the next is taken once the current one has
//   loaded the output register, so a waiting result does not hold off input
// after reset a clearing pass over max(NUM_TYPES, NUM_CUSTOMERS) entries zeroes
//   the queue flags and served counts; in_ready stays low meanwhile
// if the receiver stalls, the result holds in the output register and the
//   block stops before loading the next result
module per_key_fifo_match_counter #(
	parameter int NUM_TYPES     = pfmc_pkg::NUM_TYPES_DEF,
	parameter int NUM_CUSTOMERS = pfmc_pkg::NUM_CUSTOMERS_DEF,
	parameter int NODE_COUNT    = pfmc_pkg::NODE_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          func,
	input  logic [pfmc_pkg::TYPE_W-1:0]   item_type,
	input  logic [pfmc_pkg::CUST_W-1:0]   customer,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          matched,
	output logic [pfmc_pkg::CUST_W-1:0]   served_customer,
	output logic [pfmc_pkg::COUNT_W-1:0]  new_count,
	output logic                          dropped
);
	import pfmc_pkg::*;

	pfmc_cmd_t  cmd;
	pfmc_stat_t stat;

	pfmc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	pfmc_dp #(
		.NUM_TYPES     (NUM_TYPES),
		.NUM_CUSTOMERS (NUM_CUSTOMERS),
		.NODE_COUNT    (NODE_COUNT)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.func            (func),
		.item_type       (item_type),
		.customer        (customer),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.matched         (matched),
		.served_customer (served_customer),
		.new_count       (new_count),
		.dropped         (dropped)
	);

endmodule
